// ===== src/sais_pkg.sv =====
package sais_pkg;

	localparam int POS_W  = 4;
	localparam int DATA_W = 32;
	localparam int FIDX_W = 4;
	localparam int CNT_W  = 5;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_SEARCH = 2'd2,
		OP_READ   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_RANGE    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// Broadcast from the top level to every cell in the row.
	typedef struct packed {
		logic              ins;
		logic              del;
		logic              search;
		logic              rd;
		logic [POS_W-1:0]  pos;
		logic [DATA_W-1:0] value;
	} cell_ctrl_t;

endpackage

// ===== src/sais_cell.sv =====
module sais_cell #(
	parameter int DEPTH = 16,
	parameter int INDEX = 0
) (
	input  logic                            clk,
	input  sais_pkg::cell_ctrl_t            ctrl,
	input  logic [$clog2(DEPTH+1)-1:0]      count,
	input  logic [sais_pkg::DATA_W-1:0]     left_data,
	input  logic [sais_pkg::DATA_W-1:0]     right_data,
	output logic [sais_pkg::DATA_W-1:0]     data,
	output logic                            hit
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > sais_pkg::POS_W) ? CW : sais_pkg::POS_W;

	logic [sais_pkg::DATA_W-1:0] data_q;
	logic [PW-1:0]               idx;
	logic [PW-1:0]               pos_w;
	logic [PW-1:0]               cnt_w;
	logic                        live;

	assign idx   = PW'(INDEX);
	assign pos_w = PW'(ctrl.pos);
	assign cnt_w = PW'(count);
	assign live  = idx < cnt_w;
	assign data  = data_q;

	// Insert pulls from the lower neighbor, delete from the upper one.
	always_ff @(posedge clk) begin
		if (ctrl.ins && idx > pos_w) begin
			data_q <= left_data;
		end else if (ctrl.ins && idx == pos_w) begin
			data_q <= ctrl.value;
		end else if (ctrl.del && idx >= pos_w) begin
			data_q <= right_data;
		end
	end

	always_comb begin
		hit = 1'b0;
		if (ctrl.search) begin
			hit = live && (data_q == ctrl.value);
		end else if (ctrl.rd) begin
			hit = live && (idx == pos_w);
		end
	end

endmodule

// ===== src/sais_sel.sv =====
module sais_sel #(
	parameter int N = 16
) (
	input  logic [N-1:0]                     hit,
	input  logic [sais_pkg::DATA_W-1:0]      data [N],
	output logic                             found,
	output logic [((N > 1) ? $clog2(N) : 1)-1:0] index,
	output logic [sais_pkg::DATA_W-1:0]      sel_data
);

	localparam int L = (N > 1) ? $clog2(N) : 1;
	localparam int P = 1 << L;

	logic         node_v  [L+1][P];
	logic [L-1:0] node_ix [L+1][P];

	// Binary tree priority encoder: the lower half wins at every node.
	always_comb begin
		for (int l = 0; l <= L; l++) begin
			for (int j = 0; j < P; j++) begin
				node_v[l][j]  = 1'b0;
				node_ix[l][j] = '0;
			end
		end
		for (int j = 0; j < N; j++) begin
			node_v[0][j]  = hit[j];
			node_ix[0][j] = L'(j);
		end
		for (int l = 1; l <= L; l++) begin
			for (int j = 0; j < (P >> l); j++) begin
				node_v[l][j]  = node_v[l-1][2*j] || node_v[l-1][2*j+1];
				node_ix[l][j] = node_v[l-1][2*j] ? node_ix[l-1][2*j] : node_ix[l-1][2*j+1];
			end
		end
		found = node_v[L][0];
		index = node_ix[L][0];
	end

	// A read hits at most one cell, so an and-or selects its word.
	always_comb begin
		sel_data = '0;
		for (int j = 0; j < N; j++) begin
			sel_data = sel_data | (hit[j] ? data[j] : '0);
		end
	end

endmodule

// ===== src/shift_array_insert_delete_search_top.sv =====
// Ordered list of up to DEPTH signed 32-bit words kept in a row of cells.
// Input channel (in_valid/in_stall) carries one request: opcode, position
// and value. Insert shifts later entries up, delete shifts them down,
// search finds the lowest matching index below the count, read returns one
// entry. Output channel (out_valid/out_stall) returns one response per
// request: status, found_index, read_value and count_after.
// A request is accepted when in_valid is high and in_stall is low. At that
// edge the cells shift in parallel and the compare result of each cell is
// registered; when the compare stage advances, a priority tree over those
// bits forms the response in the output register and out_valid rises.
// Throughput is one request per cycle while the receiver keeps taking
// responses; the compare stage and the output register form the pipeline.
// When out_stall holds a response, a busy compare stage waits and in_stall
// rises until the output register drains. Reset empties the list (count is
// zero) and clears both valid flags; entry contents are not cleared.
module shift_array_insert_delete_search_top #(
	parameter int DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         opcode,
	input  logic [sais_pkg::POS_W-1:0]         position,
	input  logic signed [sais_pkg::DATA_W-1:0] value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [1:0]                         status,
	output logic [sais_pkg::FIDX_W-1:0]        found_index,
	output logic signed [sais_pkg::DATA_W-1:0] read_value,
	output logic [sais_pkg::CNT_W-1:0]         count_after
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > sais_pkg::POS_W) ? CW : sais_pkg::POS_W;
	localparam int IW = $clog2(DEPTH);

	sais_pkg::opcode_t           op;
	sais_pkg::status_t           st_now;
	sais_pkg::cell_ctrl_t        ctrl;
	logic                        accept;
	logic                        adv;
	logic [PW-1:0]               pos_w;
	logic [PW-1:0]               cnt_w;
	logic [CW-1:0]               count_q;
	logic [CW-1:0]               count_next;

	logic [sais_pkg::DATA_W-1:0] cell_data [DEPTH];
	logic [DEPTH-1:0]            cell_hit;

	logic                        busy_q;
	sais_pkg::opcode_t           op_s1;
	sais_pkg::status_t           status_s1;
	logic [CW-1:0]               count_s1;
	logic [DEPTH-1:0]            hit_s1;

	logic                        sel_found;
	logic [IW-1:0]               sel_index;
	logic [sais_pkg::DATA_W-1:0] sel_data;

	logic                        out_valid_q;
	sais_pkg::status_t           status_q;
	logic [sais_pkg::FIDX_W-1:0] found_index_q;
	logic [sais_pkg::DATA_W-1:0] read_value_q;
	logic [sais_pkg::CNT_W-1:0]  count_after_q;

	assign op       = sais_pkg::opcode_t'(opcode);
	assign pos_w    = PW'(position);
	assign cnt_w    = PW'(count_q);
	assign adv      = busy_q && (!out_valid_q || !out_stall);
	assign in_stall = busy_q && !adv;
	assign accept   = in_valid && !in_stall;

	// Status checks on the list as it stands before the request.
	always_comb begin
		st_now     = sais_pkg::ST_OK;
		count_next = count_q;
		unique case (op)
			sais_pkg::OP_INSERT: begin
				priority if (cnt_w == PW'(DEPTH)) begin
					st_now = sais_pkg::ST_FULL;
				end else if (pos_w > cnt_w) begin
					st_now = sais_pkg::ST_RANGE;
				end else begin
					count_next = count_q + CW'(1);
				end
			end
			sais_pkg::OP_DELETE: begin
				if (pos_w >= cnt_w) begin
					st_now = sais_pkg::ST_RANGE;
				end else begin
					count_next = count_q - CW'(1);
				end
			end
			sais_pkg::OP_SEARCH: begin
				st_now = sais_pkg::ST_OK;
			end
			sais_pkg::OP_READ: begin
				if (pos_w >= cnt_w) begin
					st_now = sais_pkg::ST_RANGE;
				end
			end
			default: begin
				st_now = sais_pkg::ST_OK;
			end
		endcase
	end

	always_comb begin
		ctrl.ins    = accept && (op == sais_pkg::OP_INSERT) && (st_now == sais_pkg::ST_OK);
		ctrl.del    = accept && (op == sais_pkg::OP_DELETE) && (st_now == sais_pkg::ST_OK);
		ctrl.search = op == sais_pkg::OP_SEARCH;
		ctrl.rd     = op == sais_pkg::OP_READ;
		ctrl.pos    = position;
		ctrl.value  = value;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [sais_pkg::DATA_W-1:0] left_d;
		logic [sais_pkg::DATA_W-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = cell_data[i];
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_d = cell_data[i];
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end

		sais_cell #(
			.DEPTH (DEPTH),
			.INDEX (i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.count      (count_q),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i]),
			.hit        (cell_hit[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			busy_q  <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_next;
				busy_q  <= 1'b1;
			end else if (adv) begin
				busy_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= op;
			status_s1 <= st_now;
			count_s1  <= count_next;
			hit_s1    <= cell_hit;
		end
	end

	// A read leaves the cells untouched until the response is formed, since
	// the next request is taken no earlier than that edge.
	sais_sel #(
		.N (DEPTH)
	) u_sel (
		.hit      (hit_s1),
		.data     (cell_data),
		.found    (sel_found),
		.index    (sel_index),
		.sel_data (sel_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			count_after_q <= sais_pkg::CNT_W'(count_s1);
			if (op_s1 == sais_pkg::OP_SEARCH) begin
				status_q      <= sel_found ? sais_pkg::ST_OK : sais_pkg::ST_NOTFOUND;
				found_index_q <= sel_found ? sais_pkg::FIDX_W'(sel_index) : '0;
			end else begin
				status_q      <= status_s1;
				found_index_q <= '0;
			end
			if (op_s1 == sais_pkg::OP_READ && status_s1 == sais_pkg::ST_OK) begin
				read_value_q <= sel_data;
			end else begin
				read_value_q <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_index = found_index_q;
	assign read_value  = read_value_q;
	assign count_after = count_after_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		PW'(count_q) <= PW'(DEPTH))
		else $error("list count exceeds its depth");

	a_idle_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> !in_stall)
		else $error("input stalled with an empty compare stage");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ins |=> count_q == $past(count_q) + CW'(1))
		else $error("successful insert did not grow the count");

	a_search_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		adv && op_s1 == sais_pkg::OP_SEARCH && sel_found |->
		CW'(sel_index) < count_s1)
		else $error("search matched a stale entry");

endmodule
